@@ rtl/core/lztsd_pkg.sv @@
// Shared types, field widths and head-byte decoding for the LZ token stream decoder.
// No dependencies; imported by lz_token_stream_decoder and its testbench.
package lztsd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned LEN_W   = 12;
    localparam int unsigned DIST_W  = 24;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned TAIL_W  = 32;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned FLAGS_W = 4;

    localparam int unsigned OUT_DATA_BITS = BYTE_W + LEN_W + DIST_W + TOTAL_W;
    localparam int unsigned OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

    localparam logic [FLAGS_W-1:0] FLAGS_PER_BYTE = FLAGS_W'(8);

    typedef enum logic [KIND_W-1:0] {
        KIND_LIT  = 2'd0,
        KIND_COPY = 2'd1,
        KIND_END  = 2'd2,
        KIND_BAD  = 2'd3
    } t_token_kind;

    typedef struct packed {
        t_token_kind         kind;
        logic [BYTE_W-1:0]   literal_value;
        logic [LEN_W-1:0]    copy_length;
        logic [DIST_W-1:0]   copy_distance;
        logic [TOTAL_W-1:0]  decoded_total;
    } t_result;

    // Tail bytes that follow a head byte; zero marks an undefined head (0xE0..0xFF).
    function automatic logic [PHASE_W-1:0] tail_needed(input logic [BYTE_W-1:0] head);
        logic [PHASE_W-1:0] need;
        need = '0;
        if (head[7:6] == 2'b00) begin
            need = PHASE_W'(1);
        end else if (head[7:6] == 2'b01) begin
            need = PHASE_W'(2);
        end else if (head[7:6] == 2'b10) begin
            need = PHASE_W'(1);
        end else if (head[7:4] == 4'b1100) begin
            need = PHASE_W'(3);
        end else if (head[7:4] == 4'b1101) begin
            need = PHASE_W'(4);
        end
        return need;
    endfunction

endpackage

@@ rtl/core/lz_token_stream_decoder.sv @@
// Byte-serial parser for a flag-byte LZSS token stream; emits literals, copy commands,
// end markers and bad-head reports. Depends on lztsd_pkg.
//
// Throughput: one compressed byte per cycle, sustained, while the result side keeps up.
// The result of a byte is registered into the result register, or into the skid register
// while the master side stalls; the parse state and saturating total update in the same cycle.
// A two-entry output buffer (result register plus skid register) lets the slave side keep
// taking beats while the master side stalls, until a second result is waiting.
// Reset is synchronous and active low; it clears the parse state, the byte total and both
// output entries. After reset the first byte is taken as a flag byte.
module lz_token_stream_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave side: compressed bytes.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lztsd_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] in_byte
    // Master side: decoded tokens.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] literal_value, [19:8] copy_length, [43:20] copy_distance,
    // [75:44] decoded_total, [79:76] zero
    output logic [lztsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [lztsd_pkg::KIND_W-1:0]        m_axis_tuser   // [1:0] token_kind
);
    import lztsd_pkg::*;

    // Parse state.
    logic [BYTE_W-1:0]   r_flag_bits,   n_flag_bits;
    logic [FLAGS_W-1:0]  r_flags_left,  n_flags_left;
    logic [PHASE_W-1:0]  r_token_phase, n_token_phase;
    logic [BYTE_W-1:0]   r_head_byte,   n_head_byte;
    logic [TAIL_W-1:0]   r_tail_bytes,  n_tail_bytes;
    logic [TOTAL_W-1:0]  r_output_count, n_output_count;

    // Output buffer.
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic                in_beat;
    logic                out_taken;
    logic                res_valid;
    t_result             res;
    logic [BYTE_W-1:0]   in_byte;
    logic [TAIL_W-1:0]   tail_next;
    logic [PHASE_W-1:0]  need_head;
    logic [LEN_W-1:0]    tok_len;
    logic [DIST_W-1:0]   tok_dist;
    logic [TOTAL_W:0]    count_sum;
    logic [TOTAL_W-1:0]  count_sat;

    assign in_byte       = s_axis_tdata;
    assign s_axis_tready = !r_skid_valid;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_taken     = r_out_valid && m_axis_tready;

    // The tail is gathered big-endian; tail_next includes the byte on the bus now.
    assign tail_next = {r_tail_bytes[TAIL_W-BYTE_W-1:0], in_byte};
    assign need_head = tail_needed(r_head_byte);

    // Field extraction for the five token forms, valid once the last tail byte is present.
    always_comb begin
        tok_len  = '0;
        tok_dist = '0;
        priority if (r_head_byte[7:6] == 2'b00) begin
            tok_len  = LEN_W'(r_head_byte[3:0]) + LEN_W'(3);
            tok_dist = DIST_W'({r_head_byte[5:4], tail_next[7:0]});
        end else if (r_head_byte[7:6] == 2'b01) begin
            tok_len  = LEN_W'({r_head_byte[5:0], tail_next[15:14]}) + LEN_W'(3);
            tok_dist = DIST_W'(tail_next[13:0]);
        end else if (r_head_byte[7:6] == 2'b10) begin
            tok_len  = LEN_W'({r_head_byte[5:4], tail_next[7:0]});
            tok_dist = DIST_W'(r_head_byte[3:0]);
        end else if (r_head_byte[7:4] == 4'b1100) begin
            tok_len  = LEN_W'({r_head_byte[3:0], tail_next[23:18]});
            tok_dist = DIST_W'(tail_next[17:0]);
        end else begin
            tok_len  = {r_head_byte[3:0], tail_next[31:24]};
            tok_dist = tail_next[23:0];
        end
    end

    // One saturating adder serves both literals (add one) and copies (add the length).
    always_comb begin
        logic [LEN_W-1:0] addend;
        addend    = (r_token_phase == '0) ? LEN_W'(1) : tok_len;
        count_sum = {1'b0, r_output_count} + (TOTAL_W+1)'(addend);
        count_sat = count_sum[TOTAL_W] ? '1 : count_sum[TOTAL_W-1:0];
    end

    // Byte parser.
    always_comb begin
        n_flag_bits    = r_flag_bits;
        n_flags_left   = r_flags_left;
        n_token_phase  = r_token_phase;
        n_head_byte    = r_head_byte;
        n_tail_bytes   = r_tail_bytes;
        n_output_count = r_output_count;
        res_valid      = 1'b0;
        res            = '0;
        if (in_beat) begin
            priority if (r_flags_left == '0) begin
                // Flag byte: eight new flags, consumed least significant first.
                n_flag_bits  = in_byte;
                n_flags_left = FLAGS_PER_BYTE;
            end else if (r_token_phase == '0) begin
                if (!r_flag_bits[0]) begin
                    n_flag_bits        = r_flag_bits >> 1;
                    n_flags_left       = r_flags_left - FLAGS_W'(1);
                    n_output_count     = count_sat;
                    res_valid          = 1'b1;
                    res.kind           = KIND_LIT;
                    res.literal_value  = in_byte;
                    res.decoded_total  = count_sat;
                end else if (tail_needed(in_byte) == '0) begin
                    // Undefined head byte: report it and start over from a flag byte.
                    res_valid         = 1'b1;
                    res.kind          = KIND_BAD;
                    res.decoded_total = r_output_count;
                    n_flag_bits       = '0;
                    n_flags_left      = '0;
                    n_head_byte       = '0;
                    n_tail_bytes      = '0;
                    n_output_count    = '0;
                end else begin
                    n_head_byte   = in_byte;
                    n_tail_bytes  = '0;
                    n_token_phase = PHASE_W'(1);
                end
            end else if (r_token_phase < need_head) begin
                n_tail_bytes  = tail_next;
                n_token_phase = r_token_phase + PHASE_W'(1);
            end else begin
                // Last tail byte: the token is complete.
                n_token_phase = '0;
                n_head_byte   = '0;
                n_tail_bytes  = '0;
                n_flag_bits   = r_flag_bits >> 1;
                n_flags_left  = r_flags_left - FLAGS_W'(1);
                res_valid     = 1'b1;
                if (tok_len == '0) begin
                    // Zero length marks the end of the stream; the next byte is a flag byte.
                    res.kind          = KIND_END;
                    res.decoded_total = r_output_count;
                    n_flag_bits       = '0;
                    n_flags_left      = '0;
                    n_output_count    = '0;
                end else begin
                    n_output_count    = count_sat;
                    res.kind          = KIND_COPY;
                    res.copy_length   = tok_len;
                    res.copy_distance = tok_dist;
                    res.decoded_total = count_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_bits    <= '0;
            r_flags_left   <= '0;
            r_token_phase  <= '0;
            r_head_byte    <= '0;
            r_tail_bytes   <= '0;
            r_output_count <= '0;
        end else begin
            r_flag_bits    <= n_flag_bits;
            r_flags_left   <= n_flags_left;
            r_token_phase  <= n_token_phase;
            r_head_byte    <= n_head_byte;
            r_tail_bytes   <= n_tail_bytes;
            r_output_count <= n_output_count;
        end
    end

    // Output buffer: the skid entry only fills when a new result meets a stalled output,
    // and it drains into the output register before any further beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_taken) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_taken) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_taken) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_taken) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = OUT_DATA_W'({r_out.decoded_total, r_out.copy_distance,
                                        r_out.copy_length, r_out.literal_value});

    // A held skid entry always sits behind a held output entry.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register is empty");

    // An open token can only exist while flags of the current flag byte remain, with its phase at most four.
    a_token_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_token_phase != '0) |-> (r_flags_left != '0) && (r_token_phase <= PHASE_W'(4)))
        else $error("token open without a pending flag or phase out of range");

    a_flags_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags_left <= FLAGS_PER_BYTE)
        else $error("flag counter out of range");

    // Literals never carry copy fields; copies never carry a zero length.
    a_literal_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_LIT) |->
            (r_out.copy_length == '0) && (r_out.copy_distance == '0))
        else $error("literal result carries copy fields");

    a_copy_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_COPY) |-> (r_out.copy_length != '0))
        else $error("copy command with zero length");

    // End and bad-head results restart the stream at a flag byte with a cleared count.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && (res.kind == KIND_END || res.kind == KIND_BAD)) |=>
            (r_flags_left == '0) && (r_output_count == '0) && (r_token_phase == '0))
        else $error("stream state not cleared after end or bad head");

endmodule

@@ tb/lz_token_stream_decoder_test.sv @@
// Self-checking testbench for lz_token_stream_decoder: feeds flag-byte LZ streams and
// compares every decoded token against a cycle-free predictor. Depends on lztsd_pkg.
`timescale 1ns / 1ps

module lz_token_stream_decoder_test;
    import lztsd_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1400;
    localparam int unsigned OPENING_LEN  = 26;

    // Opening stream: two literals at the byte extremes, every token form at its widest
    // fields, a copy with zero distance, an end marker, then a bad head on a fresh stream.
    localparam logic [7:0] OPENING [OPENING_LEN] = '{
        8'hFC, 8'h00, 8'hFF,
        8'h3F, 8'hFF,
        8'h7F, 8'hFF, 8'hFF,
        8'hBF, 8'hFF,
        8'hCF, 8'hFF, 8'hFF, 8'hFF,
        8'hDF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h00,
        8'h01, 8'h80, 8'h00,
        8'hFF, 8'hE0
    };

    // Predicts the decoded tokens from the accepted bytes and holds them until the
    // block delivers its own.
    class token_predictor;
        logic [7:0]  flag_bits;
        logic [3:0]  flags_left;
        logic [2:0]  token_phase;
        logic [7:0]  head;
        logic [31:0] tail;
        logic [31:0] total;
        t_result     pending_tokens[$];
        int          failures;

        function new();
            clear();
            failures = 0;
        endfunction

        function void clear();
            flag_bits   = '0;
            flags_left  = '0;
            token_phase = '0;
            head        = '0;
            tail        = '0;
            total       = '0;
        endfunction

        // Tail bytes that follow a head byte; zero for the undefined heads 0xE0..0xFF.
        function int tails_for(logic [7:0] h);
            case (h[7:6])
                2'b00, 2'b10: return 1;
                2'b01: return 2;
                default: return h[5] ? 0 : (h[4] ? 4 : 3);
            endcase
        endfunction

        function logic [31:0] add_capped(logic [31:0] a, logic [11:0] b);
            logic [32:0] sum;
            sum = {1'b0, a} + 33'(b);
            return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        endfunction

        function void consume_flag();
            flag_bits  = flag_bits >> 1;
            flags_left = flags_left - 4'd1;
        endfunction

        function void take_byte(logic [7:0] b);
            t_result     r;
            logic [11:0] len;
            logic [23:0] copy_dist;
            r = '0;
            if (flags_left == 0) begin
                flag_bits  = b;
                flags_left = 4'd8;
                return;
            end
            if (token_phase == 0) begin
                if (!flag_bits[0]) begin
                    consume_flag();
                    total           = add_capped(total, 12'd1);
                    r.kind          = KIND_LIT;
                    r.literal_value = b;
                    r.decoded_total = total;
                    pending_tokens.push_back(r);
                    return;
                end
                if (tails_for(b) == 0) begin
                    r.kind          = KIND_BAD;
                    r.decoded_total = total;
                    pending_tokens.push_back(r);
                    clear();
                    return;
                end
                head        = b;
                tail        = '0;
                token_phase = 3'd1;
                return;
            end

            // Tail bytes collect big-endian until the head's count is reached.
            tail = {tail[23:0], b};
            if (token_phase < tails_for(head)) begin
                token_phase = token_phase + 3'd1;
                return;
            end

            if (head[7:6] == 2'b00) begin
                len       = 12'(head[3:0]) + 12'd3;
                copy_dist = {14'd0, head[5:4], tail[7:0]};
            end else if (head[7:6] == 2'b01) begin
                len       = 12'({head[5:0], tail[15:14]}) + 12'd3;
                copy_dist = {10'd0, tail[13:0]};
            end else if (head[7:6] == 2'b10) begin
                len       = {2'b00, head[5:4], tail[7:0]};
                copy_dist = {20'd0, head[3:0]};
            end else if (!head[4]) begin
                len       = {2'b00, head[3:0], tail[23:18]};
                copy_dist = {6'd0, tail[17:0]};
            end else begin
                len       = {head[3:0], tail[31:24]};
                copy_dist = tail[23:0];
            end
            token_phase = '0;
            head        = '0;
            tail        = '0;
            consume_flag();

            // A zero length closes the stream; the count restarts with the next one.
            if (len == 0) begin
                r.kind          = KIND_END;
                r.decoded_total = total;
                pending_tokens.push_back(r);
                clear();
                return;
            end
            total           = add_capped(total, len);
            r.kind          = KIND_COPY;
            r.copy_length   = len;
            r.copy_distance = copy_dist;
            r.decoded_total = total;
            pending_tokens.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_token(logic [KIND_W-1:0] kind, logic [OUT_DATA_W-1:0] data);
            t_result e;
            if (pending_tokens.size() == 0) begin
                $error("token with none expected: kind %0d, data 0x%0h", kind, data);
                failures++;
                return;
            end
            e = pending_tokens.pop_front();
            compare_field("token_kind", 32'(e.kind), 32'(kind));
            compare_field("literal_value", 32'(e.literal_value), 32'(data[7:0]));
            compare_field("copy_length", 32'(e.copy_length), 32'(data[19:8]));
            compare_field("copy_distance", 32'(e.copy_distance), 32'(data[43:20]));
            compare_field("decoded_total", e.decoded_total, data[75:44]);
        endfunction

        function void report_leftover();
            if (pending_tokens.size() != 0) begin
                $error("%0d expected tokens never arrived", pending_tokens.size());
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;   // [7:0] in_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // literal, length, distance, total upward
    logic [KIND_W-1:0]     m_axis_tuser;         // [1:0] token_kind

    token_predictor predictor;
    int             bytes_accepted = 0;
    bit             end_planned    = 1'b0;

    lz_token_stream_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random byte that lands on the extremes often.
    function automatic logic [7:0] pick_value();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Chooses the next byte from the parse state that the accepted bytes have reached,
    // so that most of the stream is well formed. A few bytes are plain noise.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            return 8'($urandom);
        end
        if (predictor.flags_left == 0) begin
            end_planned = 1'b0;
            return pick_value();
        end
        if (predictor.token_phase == 0) begin
            if (!predictor.flag_bits[0]) begin
                return pick_value();
            end
            r = $urandom_range(99);
            if (r < 3) begin
                return 8'($urandom_range(255, 224));
            end
            if (r < 9) begin
                // Heads whose length field can be zero, in any of the three forms.
                end_planned = 1'b1;
                case ($urandom_range(2))
                    0: return {4'b1000, 4'($urandom)};
                    1: return 8'hC0;
                    default: return 8'hD0;
                endcase
            end
            end_planned = 1'b0;
            return 8'($urandom_range(223));
        end
        if (end_planned && predictor.token_phase == 1) begin
            end_planned = 1'b0;
            // Form 1100 keeps only the top six bits of its first tail in the length.
            if (predictor.head[7:4] == 4'b1100) begin
                return {6'd0, 2'($urandom)};
            end
            return 8'h00;
        end
        return pick_value();
    endfunction

    // Offers the opening bytes and then the random ones, idling at random except over a
    // stretch in the middle. An offered beat stays up until it is taken.
    task automatic drive_bytes();
        int sent;
        int last;
        sent = 0;
        last = OPENING_LEN + RANDOM_BYTES;
        forever begin
            @(posedge i_clk);
            if (s_axis_tvalid && s_axis_tready) begin
                predictor.take_byte(s_axis_tdata);
                sent++;
                bytes_accepted = sent;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (sent == last) begin
                    s_axis_tvalid <= 1'b0;
                    break;
                end
                if ((sent < 600 || sent > 900) && $urandom_range(99) < 37) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= (sent < OPENING_LEN) ? OPENING[sent] : pick_byte();
                end
            end
        end
    endtask

    // Result side: checks every token beat, stalls at random, and once holds off for a
    // long stretch so the output buffer fills and the input side backs up.
    initial begin
        int hold_left;
        int calm_left;
        bit hold_done;
        hold_left = 0;
        calm_left = 0;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                predictor.check_token(m_axis_tuser, m_axis_tdata);
            end
            if (!hold_done && bytes_accepted >= 500) begin
                hold_done = 1'b1;
                hold_left = 400;
                calm_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 37);
            end
        end
    end

    initial begin
        int waited;
        predictor = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drive_bytes();
        waited = 0;
        while (predictor.pending_tokens.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        // Results are registered behind their byte; a final wait catches anything stray.
        repeat (10) @(posedge i_clk);
        predictor.report_leftover();
        if (predictor.failures == 0) begin
            $display("** lz_token_stream_decoder: PASSED **");
        end else begin
            $display("** lz_token_stream_decoder: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** lz_token_stream_decoder: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lztsd_pkg.sv
rtl/core/lz_token_stream_decoder.sv
tb/lz_token_stream_decoder_test.sv
